// ===== design/deadline_timer_queue_defines.svh =====
// Assertion macros for the deadline timer queue.
// Included by the top level; depends on nothing.
// Macro names carry the DTQ prefix.
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication
`define DTQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dtq_pkg.sv =====
// Shared types and constants for the deadline timer queue.
// Used by dtq_cell and deadline_timer_queue; depends on nothing.
package dtq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 32;
  localparam int unsigned MAX_RESULTS     = 32;
  localparam int unsigned DUE_W           = 32;
  localparam int unsigned HANDLE_W        = 8;
  localparam int unsigned DELAY_W         = 16;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_EXPIRED  = 2'd2,
    ST_NONE_DUE = 2'd3
  } status_e;

  typedef enum logic {
    MODE_REGISTER = 1'b0,
    MODE_RUN      = 1'b1
  } mode_e;

  typedef struct packed {
    logic                mode;
    logic [DUE_W-1:0]    now_time;
    logic [DELAY_W-1:0]  delay;
    logic [HANDLE_W-1:0] handle;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] out_handle;
    logic [DUE_W-1:0]    due_time;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== design/dtq_cell.sv =====
// One slot of the sorted chain: holds a due time and a handle.
// Shifts right on insert behind the insertion point, left on pop.
// Depends on dtq_pkg.
module dtq_cell (
  input  logic                         clk_i,
  input  dtq_pkg::cell_ctrl_t          ctrl_i,
  input  logic                         valid_i,
  input  logic [dtq_pkg::DUE_W-1:0]    new_due_i,
  input  logic [dtq_pkg::HANDLE_W-1:0] new_handle_i,
  input  logic                         left_gt_i,
  input  logic [dtq_pkg::DUE_W-1:0]    left_due_i,
  input  logic [dtq_pkg::HANDLE_W-1:0] left_handle_i,
  input  logic [dtq_pkg::DUE_W-1:0]    right_due_i,
  input  logic [dtq_pkg::HANDLE_W-1:0] right_handle_i,
  output logic [dtq_pkg::DUE_W-1:0]    due_o,
  output logic [dtq_pkg::HANDLE_W-1:0] handle_o,
  output logic                         gt_o
);
  import dtq_pkg::*;

  logic [DUE_W-1:0]    due_q, due_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;

  // empty slots count as later than anything
  assign gt_o = !valid_i || (due_q > new_due_i);

  always_comb begin
    due_d    = due_q;
    handle_d = handle_q;
    if (ctrl_i.ins && gt_o) begin
      if (left_gt_i) begin
        due_d    = left_due_i;
        handle_d = left_handle_i;
      end else begin
        due_d    = new_due_i;
        handle_d = new_handle_i;
      end
    end else if (ctrl_i.pop) begin
      due_d    = right_due_i;
      handle_d = right_handle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    due_q    <= due_d;
    handle_q <= handle_d;
  end

  assign due_o    = due_q;
  assign handle_o = handle_q;

endmodule

// ===== design/deadline_timer_queue.sv =====
// Deadline timer queue top level: control sequencer, occupancy and result register.
// Depends on dtq_pkg, dtq_cell and deadline_timer_queue_defines.svh.
//
// Usage: drive item_i and raise start; the item is taken at a clock edge where
// start is high and busy is low. Results appear on res_o for exactly one cycle,
// marked by res_strobe_o; the receiver cannot hold them off.
// Register item (mode 0): one result (accepted or refused), last set, registered
// from the insert state. busy is high for one cycle, so items cannot go back to back.
// Run item (mode 1): the chain head is compared with now_time once a cycle;
// each expired entry is emitted and popped in its own cycle, earliest first,
// up to MAX_RESULTS per item, last set on the final one. With nothing due one
// result with status nothing-due follows; busy stays high for the whole run.
// On insert every cell compares its due time with the new one in parallel
// and the chain shifts right behind the insertion point.
// Reset empties the queue (occupancy zero) and clears the sequencer; slot
// contents are not cleared and need no clearing pass.
module deadline_timer_queue #(
  parameter int unsigned QueueDepth = dtq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  dtq_pkg::in_item_t   item_i,
  output logic                res_strobe_o,
  output dtq_pkg::out_item_t  res_o
);
  import dtq_pkg::*;

  `include "deadline_timer_queue_defines.svh"

  localparam int unsigned OccW = $clog2(QueueDepth + 1);
  localparam int unsigned CntW = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StIns  = 2'd1;
  localparam logic [1:0] StRun  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [OccW-1:0]     occ_q, occ_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DUE_W-1:0]    now_q, due_q;
  logic [HANDLE_W-1:0] handle_q;
  logic                res_strobe_q, res_strobe_d;
  out_item_t           res_q, res_d;

  cell_ctrl_t          ctrl;
  logic [DUE_W-1:0]    cell_due [QueueDepth];
  logic [HANDLE_W-1:0] cell_handle [QueueDepth];
  logic                cell_gt [QueueDepth];

  logic                accept;
  logic [DELAY_W-1:0]  dly_eff;
  logic [DUE_W:0]      due_sum;
  logic [DUE_W-1:0]    due_sat;
  logic                full;
  logic                head_ok, next_ok;

  assign accept  = start && !busy;
  assign busy    = (state_q != StIdle);
  assign dly_eff = (item_i.delay == '0) ? DELAY_W'(1) : item_i.delay;
  assign due_sum = {1'b0, item_i.now_time} + {{(DUE_W + 1 - DELAY_W){1'b0}}, dly_eff};
  assign due_sat = due_sum[DUE_W] ? '1 : due_sum[DUE_W-1:0];
  assign full    = (occ_q == OccW'(QueueDepth));

  assign head_ok = (occ_q != '0) && (cell_due[0] <= now_q) && (cnt_q != CntW'(MAX_RESULTS));
  assign next_ok = (occ_q > OccW'(1)) && (cell_due[1] <= now_q)
                   && ((cnt_q + CntW'(1)) != CntW'(MAX_RESULTS));

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic                valid;
    logic                left_gt;
    logic [DUE_W-1:0]    left_due, right_due;
    logic [HANDLE_W-1:0] left_handle, right_handle;

    assign valid = (OccW'(i) < occ_q);

    if (i == 0) begin : g_head
      assign left_gt     = 1'b0;
      assign left_due    = '0;
      assign left_handle = '0;
    end else begin : g_mid
      assign left_gt     = cell_gt[i-1];
      assign left_due    = cell_due[i-1];
      assign left_handle = cell_handle[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      assign right_due    = cell_due[i];
      assign right_handle = cell_handle[i];
    end else begin : g_body
      assign right_due    = cell_due[i+1];
      assign right_handle = cell_handle[i+1];
    end

    dtq_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .valid_i        (valid),
      .new_due_i      (due_q),
      .new_handle_i   (handle_q),
      .left_gt_i      (left_gt),
      .left_due_i     (left_due),
      .left_handle_i  (left_handle),
      .right_due_i    (right_due),
      .right_handle_i (right_handle),
      .due_o          (cell_due[i]),
      .handle_o       (cell_handle[i]),
      .gt_o           (cell_gt[i])
    );
  end

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    cnt_d        = cnt_q;
    ctrl         = '0;
    res_strobe_d = 1'b0;
    res_d        = res_q;
    unique case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (accept) begin
          state_d = (item_i.mode == MODE_RUN) ? StRun : StIns;
        end
      end
      StIns: begin
        res_strobe_d     = 1'b1;
        res_d.status     = full ? ST_REFUSED : ST_ACCEPTED;
        res_d.out_handle = handle_q;
        res_d.due_time   = due_q;
        res_d.last       = 1'b1;
        if (!full) begin
          ctrl.ins = 1'b1;
          occ_d    = occ_q + OccW'(1);
        end
        state_d = StIdle;
      end
      StRun: begin
        res_strobe_d = 1'b1;
        if (head_ok) begin
          res_d.status     = ST_EXPIRED;
          res_d.out_handle = cell_handle[0];
          res_d.due_time   = cell_due[0];
          res_d.last       = !next_ok;
          ctrl.pop         = 1'b1;
          occ_d            = occ_q - OccW'(1);
          cnt_d            = cnt_q + CntW'(1);
          if (!next_ok) begin
            state_d = StIdle;
          end
        end else begin
          res_d.status     = ST_NONE_DUE;
          res_d.out_handle = '0;
          res_d.due_time   = now_q;
          res_d.last       = 1'b1;
          state_d          = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      occ_q        <= '0;
      cnt_q        <= '0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      occ_q        <= occ_d;
      cnt_q        <= cnt_d;
      res_strobe_q <= res_strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      now_q    <= item_i.now_time;
      due_q    <= due_sat;
      handle_q <= item_i.handle;
    end
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

  `DTQ_ASSERT_IMP(a_occ_bound, clk_i, rst_ni, 1'b1, occ_q <= OccW'(QueueDepth), "occupancy overflow")
  `DTQ_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, accept, busy, "busy low after accept")
  `DTQ_ASSERT_IMP(a_refuse_full, clk_i, rst_ni, res_strobe_o && (res_o.status == ST_REFUSED), occ_q == OccW'(QueueDepth), "refused while not full")
  `DTQ_ASSERT_IMP(a_pop_limit, clk_i, rst_ni, state_q == StRun, cnt_q < CntW'(MAX_RESULTS), "burst limit exceeded")

endmodule

// ===== dv/tb_top.sv =====
// Testbench for deadline_timer_queue: directed table, then random register/run episodes.
// Results are checked against a bench sorted-queue predictor or a directed row's want.
// Depends on dtq_pkg and the deadline_timer_queue RTL.
module tb_top;
  import dtq_pkg::*;

  localparam int          DEPTH       = QUEUE_DEPTH_DEF;
  localparam int          BURST_MAX   = MAX_RESULTS;
  localparam int          ITEM_TARGET = 480;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          DRAIN_CYCLES = 40;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_item_t  cmd_item;
  logic      res_strobe;
  out_item_t res;

  deadline_timer_queue #(
    .QueueDepth(DEPTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (cmd_item),
    .res_strobe_o(res_strobe),
    .res_o       (res)
  );

  // predictor state: sorted by due time, ties in arrival order
  logic [DUE_W-1:0]    mdl_due    [DEPTH];
  logic [HANDLE_W-1:0] mdl_handle [DEPTH];
  int                  mdl_count;

  out_item_t   step_results[$];
  out_item_t   pending_results[$];
  dir_row_t    directed_rows[$];

  int          err_count;
  int          items_sent;
  int          cnt_register;
  int          cnt_refused;
  int          cnt_run;
  int          cnt_expired;
  int unsigned cycle_count = 0;
  logic [DUE_W-1:0] sim_now;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic in_item_t make_item(mode_e m, logic [DUE_W-1:0] now,
                                         logic [DELAY_W-1:0] dly, logic [HANDLE_W-1:0] h);
    in_item_t it;
    it.mode     = m;
    it.now_time = now;
    it.delay    = dly;
    it.handle   = h;
    return it;
  endfunction

  function automatic out_item_t make_result(status_e st, logic [HANDLE_W-1:0] h,
                                            logic [DUE_W-1:0] d, logic l);
    out_item_t r;
    r.status     = st;
    r.out_handle = h;
    r.due_time   = d;
    r.last       = l;
    return r;
  endfunction

  function automatic dir_row_t make_row(in_item_t it, logic typed, out_item_t want);
    dir_row_t r;
    r.item  = it;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  task automatic add_row(input dir_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endtask

  task automatic add_step(input out_item_t r);
    step_results.insert(step_results.size(), r);
  endtask

  task automatic add_pending(input out_item_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic predict_timer_item(input in_item_t it);
    logic [DUE_W:0]   sum;
    logic [DUE_W-1:0] due;
    int               pos;
    int               n;
    int               i;
    step_results.delete();
    if (it.mode == MODE_REGISTER) begin
      cnt_register++;
      sum = {1'b0, it.now_time} + ((it.delay == '0) ? 33'd1 : {17'd0, it.delay});
      due = sum[DUE_W] ? '1 : sum[DUE_W-1:0];
      if (mdl_count >= DEPTH) begin
        cnt_refused++;
        add_step(make_result(ST_REFUSED, it.handle, due, 1'b1));
      end else begin
        pos = 0;
        while (pos < mdl_count && mdl_due[pos] <= due) pos++;
        for (i = mdl_count; i > pos; i--) begin
          mdl_due[i]    = mdl_due[i-1];
          mdl_handle[i] = mdl_handle[i-1];
        end
        mdl_due[pos]    = due;
        mdl_handle[pos] = it.handle;
        mdl_count++;
        add_step(make_result(ST_ACCEPTED, it.handle, due, 1'b1));
      end
    end else begin
      cnt_run++;
      n = 0;
      while (n < mdl_count && n < BURST_MAX && mdl_due[n] <= it.now_time) n++;
      if (n == 0) begin
        add_step(make_result(ST_NONE_DUE, '0, it.now_time, 1'b1));
      end else begin
        cnt_expired += n;
        for (i = 0; i < n; i++)
          add_step(make_result(ST_EXPIRED, mdl_handle[i], mdl_due[i], (i == n - 1)));
        for (i = n; i < mdl_count; i++) begin
          mdl_due[i-n]    = mdl_due[i];
          mdl_handle[i-n] = mdl_handle[i];
        end
        mdl_count -= n;
      end
    end
  endtask

  // holds start high until the item is taken, then queues what it should produce
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    start    <= 1'b1;
    cmd_item <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    predict_timer_item(it);
    if (typed) add_pending(want);
    else foreach (step_results[k]) add_pending(step_results[k]);
  endtask

  task automatic send_plain(input in_item_t it);
    send_item(it, 1'b0, '0);
    idle_gap();
  endtask

  task automatic idle_gap();
    int r;
    int gap;
    r = $urandom_range(0, 19);
    if (r < 10) gap = 0;
    else if (r < 17) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [DELAY_W-1:0] rand_delay();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return DELAY_W'($urandom);
    return DELAY_W'($urandom_range(1, 40));
  endfunction

  task automatic advance_now(input int unsigned step);
    logic [DUE_W:0] t;
    t = {1'b0, sim_now} + {1'b0, step};
    sim_now = t[DUE_W] ? '1 : t[DUE_W-1:0];
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && res_strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d handle %0h due %0h last %0b",
               res.status, res.out_handle, res.due_time, res.last);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (res.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res.status);
          err_count++;
        end
        if (res.out_handle !== want.out_handle) begin
          $error("out_handle: expected %0h, got %0h", want.out_handle, res.out_handle);
          err_count++;
        end
        if (res.due_time !== want.due_time) begin
          $error("due_time: expected %0h, got %0h", want.due_time, res.due_time);
          err_count++;
        end
        if (res.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, res.last);
          err_count++;
        end
      end
    end
  end

  initial begin
    int episode;
    int len;
    int j;
    logic [DELAY_W-1:0] tie_dly;

    rst_ni       = 1'b0;
    start        = 1'b0;
    cmd_item     = '0;
    err_count    = 0;
    items_sent   = 0;
    cnt_register = 0;
    cnt_refused  = 0;
    cnt_run      = 0;
    cnt_expired  = 0;
    mdl_count    = 0;
    sim_now      = '0;

    add_row(make_row(make_item(MODE_RUN, 32'd0, 16'd0, 8'h00), 1'b1,
                     make_result(ST_NONE_DUE, 8'h00, 32'd0, 1'b1)));
    add_row(make_row(make_item(MODE_REGISTER, 32'd0, 16'd0, 8'hFF), 1'b1,
                     make_result(ST_ACCEPTED, 8'hFF, 32'd1, 1'b1)));
    add_row(make_row(make_item(MODE_REGISTER, 32'd0, 16'd1, 8'h01), 1'b1,
                     make_result(ST_ACCEPTED, 8'h01, 32'd1, 1'b1)));
    add_row(make_row(make_item(MODE_REGISTER, 32'd5, 16'hFFFF, 8'hAA), 1'b0, '0));
    // due time saturates
    add_row(make_row(make_item(MODE_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, 8'h00), 1'b1,
                     make_result(ST_ACCEPTED, 8'h00, 32'hFFFF_FFFF, 1'b1)));
    add_row(make_row(make_item(MODE_REGISTER, 32'hFFFF_FF00, 16'h00FF, 8'h33), 1'b0, '0));
    add_row(make_row(make_item(MODE_RUN, 32'd0, 16'hFFFF, 8'hFF), 1'b1,
                     make_result(ST_NONE_DUE, 8'h00, 32'd0, 1'b1)));
    add_row(make_row(make_item(MODE_RUN, 32'd1, 16'd0, 8'h00), 1'b0, '0));
    add_row(make_row(make_item(MODE_RUN, 32'd1, 16'd0, 8'h00), 1'b1,
                     make_result(ST_NONE_DUE, 8'h00, 32'd1, 1'b1)));
    add_row(make_row(make_item(MODE_REGISTER, 32'd100, 16'd0, 8'h80), 1'b0, '0));
    add_row(make_row(make_item(MODE_REGISTER, 32'd100, 16'd0, 8'h7F), 1'b0, '0));
    add_row(make_row(make_item(MODE_REGISTER, 32'd99, 16'd2, 8'h40), 1'b0, '0));
    add_row(make_row(make_item(MODE_RUN, 32'hFFFF_FFFE, 16'd0, 8'h00), 1'b0, '0));
    add_row(make_row(make_item(MODE_RUN, 32'hFFFF_FFFF, 16'd0, 8'h00), 1'b0, '0));
    add_row(make_row(make_item(MODE_RUN, 32'hFFFF_FFFF, 16'd0, 8'h00), 1'b1,
                     make_result(ST_NONE_DUE, 8'h00, 32'hFFFF_FFFF, 1'b1)));
    add_row(make_row(make_item(MODE_REGISTER, 32'd0, 16'h8000, 8'h5A), 1'b0, '0));
    add_row(make_row(make_item(MODE_REGISTER, 32'h1234_5678, 16'h1234, 8'hA5), 1'b0, '0));
    add_row(make_row(make_item(MODE_RUN, 32'hFFFF_FFFF, 16'd0, 8'h00), 1'b0, '0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      idle_gap();
    end

    while (items_sent < ITEM_TARGET) begin
      episode = $urandom_range(0, 9);
      if (episode <= 4) begin
        len = $urandom_range(4, 20);
        for (j = 0; j < len; j++) begin
          if ($urandom_range(0, 9) < 6) begin
            send_plain(make_item(MODE_REGISTER, sim_now, rand_delay(),
                                 HANDLE_W'($urandom)));
          end else begin
            advance_now($urandom_range(0, 30));
            send_plain(make_item(MODE_RUN, sim_now, DELAY_W'($urandom),
                                 HANDLE_W'($urandom)));
          end
        end
      end else if (episode <= 6) begin
        // fill to full, push a few refused items, then two runs drain what is due
        while (mdl_count < DEPTH)
          send_plain(make_item(MODE_REGISTER, sim_now, DELAY_W'($urandom_range(0, 60)),
                               HANDLE_W'($urandom)));
        len = $urandom_range(1, 3);
        for (j = 0; j < len; j++)
          send_plain(make_item(MODE_REGISTER, sim_now, rand_delay(), HANDLE_W'($urandom)));
        advance_now(61);
        send_plain(make_item(MODE_RUN, sim_now, '0, '0));
        send_plain(make_item(MODE_RUN, sim_now, '0, '0));
      end else if (episode == 7) begin
        len     = $urandom_range(2, 6);
        tie_dly = DELAY_W'($urandom_range(0, 20));
        for (j = 0; j < len; j++)
          send_plain(make_item(MODE_REGISTER, sim_now, tie_dly, HANDLE_W'($urandom)));
        advance_now($urandom_range(0, 25));
        send_plain(make_item(MODE_RUN, sim_now, '0, HANDLE_W'($urandom)));
      end else if (episode == 8) begin
        len = $urandom_range(3, 8);
        for (j = 0; j < len; j++)
          send_plain(make_item(mode_e'($urandom_range(0, 1)), DUE_W'($urandom),
                               DELAY_W'($urandom), HANDLE_W'($urandom)));
      end else begin
        if ($urandom_range(0, 1) == 0)
          sim_now = 32'hFFFF_FFFF - $urandom_range(0, 100000);
        else
          sim_now = $urandom_range(0, 1000);
        send_plain(make_item(MODE_RUN, sim_now, '0, '0));
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d items: %0d registers (%0d refused), %0d runs, %0d expiries.",
             items_sent, cnt_register, cnt_refused, cnt_run, cnt_expired);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/dtq_pkg.sv
design/dtq_cell.sv
design/deadline_timer_queue.sv
dv/tb_top.sv
